// ===== design/jpsd_pkg.sv =====
package jpsd_pkg;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [31:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic               status;
        logic               last;
    } t_out_item;

    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_LOAD_X = 2'd2;
    localparam logic [1:0] FUNC_RUN    = 2'd3;

    localparam logic [3:0] REG_SIZE  = 4'd0;
    localparam logic [3:0] REG_ITERS = 4'd1;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // 64-bit saturation to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7fffffff;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

// ===== design/jpsd_div.sv =====
// signed restoring divider: q = sat32((p << FRAC_BITS) / d), truncating,
// one quotient bit per cycle
module jpsd_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quo
);
    import jpsd_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [NW:0]   r_rem;
    logic [31:0]   r_d;
    logic          r_neg;
    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] n_abs;
    logic [NW:0]   n_rem;
    logic [NW:0]   n_trial;
    logic signed [63:0] n_sq;

    always_comb begin
        logic signed [NW-1:0] sn;
        sn = NW'($signed(i_num)) <<< FRAC_BITS;
        n_abs = sn[NW-1] ? NW'(-sn) : NW'(sn);
        n_rem = {r_rem[NW-1:0], r_q[NW-1]};
        n_trial = n_rem - (NW+1)'(r_d);
        n_sq = r_neg ? -$signed({1'b0, 63'(r_q)}) : $signed({1'b0, 63'(r_q)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= n_abs;
                r_rem  <= '0;
                r_d    <= i_den[31] ? 32'(-i_den) : 32'(i_den);
                r_neg  <= i_num[31] ^ i_den[31];
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_quo  <= sat32(n_sq);
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                    if (!n_trial[NW]) begin
                        r_rem <= n_trial;
                        r_q   <= {r_q[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rem;
                        r_q   <= {r_q[NW-2:0], 1'b0};
                    end
                end
            end
        end
    end
endmodule

// ===== design/jpsd_mac.sv =====
// shared multiply unit: registered product, then floor shift
module jpsd_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_q
);
    logic signed [63:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_q = r_p >>> FRAC_BITS;
endmodule

// ===== design/jacobi_preconditioned_steepest_descent.sv =====
// Jacobi-preconditioned steepest descent solver, Q16.16 fixed point.
// Input channel (i_in_*): load items write A[row][col], b[row] or x[row]; a
// run item forms r = Ax - b and performs iteration_count iterations, then
// emits x element by element on the output channel (o_out_*), last set on
// the final element, or one status item on a zero diagonal or zero
// denominator.
// A run uses one shared multiplier for every multiply-accumulate; the
// residual is formed once, then each iteration performs the diagonal
// divisions, A*u, the two dot products, the division giving t and the
// updates. A*u dominates for large n.
// Each element is loaded into the output register in S_EMIT_RD and held in S_EMIT until accepted.
// The block takes no new item while a run is in progress.
// Output is held in a register; a stalled receiver stalls the emission of x
// and nothing is lost.
// Reset sets the size register to 16 and the iteration register to 1; store contents stay undefined until written.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once; the user must
// issue them only while the block is idle, and the block itself does not enforce this.
module jacobi_preconditioned_steepest_descent #(
    parameter int MAX_ORDER = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  jpsd_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output jpsd_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [jpsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jpsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import jpsd_pkg::*;

    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;
    localparam int LIM = (MAX_ORDER < 16) ? MAX_ORDER : 16;
    localparam int NW = $clog2(LIM + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RES_RD, S_RES_MUL, S_RES_ACC, S_RES_WR,
        S_DIAG_RD, S_DIAG_CHK, S_DIAG_WAIT,
        S_AU_RD, S_AU_MUL, S_AU_ACC, S_AU_WR,
        S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_DOT_END,
        S_T_WAIT, S_UPD_RD, S_UPD_MX, S_UPD_X, S_UPD_MR, S_UPD_R,
        S_EMIT_RD, S_EMIT, S_FAIL
    } t_state;

    function automatic logic [AW-1:0] a_addr(input logic [IW-1:0] row,
                                             input logic [IW-1:0] col);
        return AW'(MAX_ORDER * 32'(row) + 32'(col));
    endfunction

    logic signed [31:0] r_mem_a [MAX_ORDER*MAX_ORDER];
    logic signed [31:0] r_mem_b [MAX_ORDER];
    logic signed [31:0] r_mem_x [MAX_ORDER];
    logic signed [31:0] r_mem_r [MAX_ORDER];
    logic signed [31:0] r_mem_u [MAX_ORDER];
    logic signed [31:0] r_mem_v [MAX_ORDER];

    t_state             r_state;
    logic [NW-1:0]      r_n;
    logic [15:0]        r_m;
    logic [4:0]         r_size;
    logic [15:0]        r_iters;
    logic [IW-1:0]      r_i, r_j;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_a_rd, r_v1, r_v2, r_v3, r_t, r_den;
    logic               r_dot_sel;
    logic signed [31:0] r_ma, r_mb;
    logic               r_div_go;
    logic signed [31:0] r_dn, r_dd;
    logic               div_done;
    logic signed [31:0] div_q;
    logic signed [63:0] mul_q;
    logic [IW-1:0]      n_last;

    jpsd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk(i_clk), .i_a(r_ma), .i_b(r_mb), .o_q(mul_q));

    jpsd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(r_dn), .i_den(r_dd), .o_done(div_done), .o_quo(div_q));

    assign o_in_ready = (r_state == S_IDLE);
    assign n_last = IW'(r_n - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= 5'd16;
            r_iters <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SIZE:  r_size  <= i_cfg_data[4:0];
                REG_ITERS: r_iters <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
        end else begin
            // divider starts after a nonzero diagonal check or once (u,r) is done
            r_div_go <= (r_state == S_DIAG_CHK && r_dd != 32'sd0) ||
                        (r_state == S_DOT_END && r_dot_sel);
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (i_in_data.func)
                            FUNC_LOAD_A: if (32'(i_in_data.row_index) < MAX_ORDER &&
                                             32'(i_in_data.col_index) < MAX_ORDER)
                                r_mem_a[a_addr(IW'(i_in_data.row_index),
                                               IW'(i_in_data.col_index))]
                                    <= i_in_data.load_value;
                            FUNC_LOAD_B: if (32'(i_in_data.row_index) < MAX_ORDER)
                                r_mem_b[IW'(i_in_data.row_index)] <= i_in_data.load_value;
                            FUNC_LOAD_X: if (32'(i_in_data.row_index) < MAX_ORDER)
                                r_mem_x[IW'(i_in_data.row_index)] <= i_in_data.load_value;
                            FUNC_RUN: begin
                                if (r_size == 5'd0) r_n <= NW'(1);
                                else if (32'(r_size) > LIM) r_n <= NW'(LIM);
                                else r_n <= NW'(r_size);
                                r_m   <= r_iters;
                                r_i   <= '0;
                                r_j   <= '0;
                                r_acc <= '0;
                                r_state <= S_RES_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                // r = A x - b
                S_RES_RD: begin
                    r_ma <= r_mem_a[a_addr(r_i, r_j)];
                    r_mb <= r_mem_x[r_j];
                    r_state <= S_RES_MUL;
                end
                S_RES_MUL: r_state <= S_RES_ACC;
                S_RES_ACC: begin
                    r_acc <= r_acc + mul_q;
                    if (r_j == n_last) r_state <= S_RES_WR;
                    else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_RES_RD;
                    end
                end
                S_RES_WR: begin
                    r_mem_r[r_i] <= sat32(r_acc - 64'(r_mem_b[r_i]));
                    r_acc <= '0;
                    r_j   <= '0;
                    if (r_i == n_last) begin
                        r_i <= '0;
                        r_state <= (r_m == 16'd0) ? S_EMIT_RD : S_DIAG_RD;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_RES_RD;
                    end
                end
                // u = D^-1 r
                S_DIAG_RD: begin
                    r_dd <= r_mem_a[a_addr(r_i, r_i)];
                    r_dn <= r_mem_r[r_i];
                    r_state <= S_DIAG_CHK;
                end
                S_DIAG_CHK: begin
                    if (r_dd == 32'sd0) r_state <= S_FAIL;
                    else r_state <= S_DIAG_WAIT;
                end
                S_DIAG_WAIT: begin
                    if (div_done) begin
                        r_mem_u[r_i] <= div_q;
                        if (r_i == n_last) begin
                            r_i <= '0;
                            r_j <= '0;
                            r_acc <= '0;
                            r_state <= S_AU_RD;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_DIAG_RD;
                        end
                    end
                end
                // v = A u
                S_AU_RD: begin
                    r_ma <= r_mem_a[a_addr(r_i, r_j)];
                    r_mb <= r_mem_u[r_j];
                    r_state <= S_AU_MUL;
                end
                S_AU_MUL: r_state <= S_AU_ACC;
                S_AU_ACC: begin
                    r_acc <= r_acc + mul_q;
                    if (r_j == n_last) r_state <= S_AU_WR;
                    else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_AU_RD;
                    end
                end
                S_AU_WR: begin
                    r_mem_v[r_i] <= sat32(r_acc);
                    r_acc <= '0;
                    r_j   <= '0;
                    if (r_i == n_last) begin
                        r_i <= '0;
                        r_dot_sel <= 1'b0;
                        r_state <= S_DOT_RD;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_AU_RD;
                    end
                end
                // (v,u) first, then (u,r)
                S_DOT_RD: begin
                    r_ma <= r_mem_u[r_i];
                    r_mb <= r_dot_sel ? r_mem_r[r_i] : r_mem_v[r_i];
                    r_state <= S_DOT_MUL;
                end
                S_DOT_MUL: r_state <= S_DOT_ACC;
                S_DOT_ACC: begin
                    r_acc <= r_acc + mul_q;
                    if (r_i == n_last) r_state <= S_DOT_END;
                    else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_DOT_RD;
                    end
                end
                S_DOT_END: begin
                    r_acc <= '0;
                    r_i   <= '0;
                    if (!r_dot_sel) begin
                        r_den <= sat32(r_acc);
                        if (sat32(r_acc) == 32'sd0) r_state <= S_FAIL;
                        else begin
                            r_dot_sel <= 1'b1;
                            r_state <= S_DOT_RD;
                        end
                    end else begin
                        r_dn <= sat32(r_acc);
                        r_dd <= r_den;
                        r_state <= S_T_WAIT;
                    end
                end
                S_T_WAIT: begin
                    if (div_done) begin
                        r_t <= div_q;
                        r_state <= S_UPD_RD;
                    end
                end
                // x -= t u, r -= t v
                S_UPD_RD: begin
                    r_v1 <= r_mem_x[r_i];
                    r_v2 <= r_mem_r[r_i];
                    r_v3 <= r_mem_v[r_i];
                    r_ma <= r_t;
                    r_mb <= r_mem_u[r_i];
                    r_state <= S_UPD_MX;
                end
                S_UPD_MX: r_state <= S_UPD_X;
                S_UPD_X: begin
                    r_mem_x[r_i] <= sat32(64'(r_v1) - mul_q);
                    r_mb <= r_v3;
                    r_a_rd <= r_v2;
                    r_state <= S_UPD_MR;
                end
                // product of t and v is registered in S_UPD_MR and used in S_UPD_R
                S_UPD_MR: r_state <= S_UPD_R;
                S_UPD_R: begin
                    r_mem_r[r_i] <= sat32(64'(r_a_rd) - mul_q);
                    if (r_i == n_last) begin
                        r_i <= '0;
                        r_m <= r_m - 1'b1;
                        r_state <= (r_m == 16'd1) ? S_EMIT_RD : S_DIAG_RD;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_UPD_RD;
                    end
                end
                S_EMIT_RD: begin
                    o_out_data.element_index <= 4'(r_i);
                    o_out_data.element_value <= r_mem_x[r_i];
                    o_out_data.status <= 1'b0;
                    o_out_data.last <= (r_i == n_last);
                    o_out_valid <= 1'b1;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        if (r_i == n_last) r_state <= S_IDLE;
                        else begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_FAIL: begin
                    o_out_data.element_index <= 4'd0;
                    o_out_data.element_value <= 32'sd0;
                    o_out_data.status <= 1'b1;
                    o_out_data.last <= 1'b1;
                    o_out_valid <= 1'b1;
                    r_i <= n_last;
                    r_state <= S_EMIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
